// ===== design/rwc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwc_pkg
// Shared types, tags and helpers for the RIFF/WAVE chunk parser.
// ----------------------------------------------------------------------------
package rwc_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [5:0]  FMT_MIN  = 6'd16;
    localparam logic [5:0]  FMT_EXT  = 6'd40;
    localparam logic [15:0] EXT_MIN  = 16'd22;

    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_FORMAT = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_NOT_RIFF  = 3'd2;
    localparam logic [2:0] ST_NOT_WAVE  = 3'd3;
    localparam logic [2:0] ST_OVERRUN   = 3'd4;
    localparam logic [2:0] ST_FMT_SMALL = 3'd5;
    localparam logic [2:0] ST_NO_DATA   = 3'd6;

    localparam int TDATA_W = 160;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  sample_byte;
        logic        chunk_end;
        logic [15:0] channels;
        logic [31:0] rate_hz;
        logic [31:0] bytes_per_sec;
        logic [15:0] frame_bytes;
        logic [15:0] sample_bits;
        logic [31:0] speaker_mask;
        logic [2:0]  status;
        logic        last;
    } res_t;

    function automatic logic [31:0] put_byte32(input logic [31:0] v, input logic [1:0] idx,
                                               input logic [7:0] b);
        logic [31:0] r;
        r = v;
        unique case (idx)
            2'd0: r[7:0]   = b;
            2'd1: r[15:8]  = b;
            2'd2: r[23:16] = b;
            2'd3: r[31:24] = b;
            default: r = v;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] put_byte16(input logic [15:0] v, input logic idx,
                                               input logic [7:0] b);
        logic [15:0] r;
        r = v;
        if (idx) begin
            r[15:8] = b;
        end else begin
            r[7:0] = b;
        end
        return r;
    endfunction

endpackage

// ===== design/rwc_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwc_cfg
// APB register block holding the extended format enable bit.
// ----------------------------------------------------------------------------
module rwc_cfg
    import rwc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic        ext_en
);

    logic ext_en_reg;
    logic ext_en_next;

    always_comb begin
        ext_en_next = ext_en_reg;
        if (psel && penable && pwrite && !paddr[2]) begin
            ext_en_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_en_reg <= 1'b1;
        end else begin
            ext_en_reg <= ext_en_next;
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {31'd0, ext_en_reg};
    assign pready = 1'b1;
    assign ext_en = ext_en_reg;

endmodule

// ===== design/rwc_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwc_parser
// Per-byte header walker: tag checks, chunk tracking, fmt capture and status.
// ----------------------------------------------------------------------------
module rwc_parser
    import rwc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_take,
    input  logic [7:0] in_byte,
    input  logic       in_eof,
    input  logic       ext_en,
    output res_t       res_a,
    output res_t       res_b,
    output logic [1:0] res_cnt
);

    localparam logic [2:0] PH_RIFF  = 3'd0;
    localparam logic [2:0] PH_RSIZE = 3'd1;
    localparam logic [2:0] PH_WAVE  = 3'd2;
    localparam logic [2:0] PH_CID   = 3'd3;
    localparam logic [2:0] PH_CSIZE = 3'd4;
    localparam logic [2:0] PH_BODY  = 3'd5;
    localparam logic [2:0] PH_PAD   = 3'd6;
    localparam logic [2:0] PH_DEAD  = 3'd7;

    logic [2:0]  phase_reg,   phase_next;
    logic [1:0]  fidx_reg,    fidx_next;
    logic [31:0] fshift_reg,  fshift_next;
    logic [31:0] tag_reg,     tag_next;
    logic [31:0] left_reg,    left_next;
    logic [5:0]  foff_reg,    foff_next;
    logic [15:0] ext_reg,     ext_next;
    logic [15:0] chan_reg,    chan_next;
    logic [31:0] srate_reg,   srate_next;
    logic [31:0] brate_reg,   brate_next;
    logic [15:0] align_reg,   align_next;
    logic [15:0] bits_reg,    bits_next;
    logic [31:0] mask_reg,    mask_next;
    logic [3:0]  seen_reg,    seen_next;
    logic        odd_reg,     odd_next;
    logic        dseen_reg,   dseen_next;
    logic [2:0]  err_reg,     err_next;

    logic [31:0] word;
    logic [32:0] fmt_size;
    logic        do_finish;
    logic        emit_first;
    res_t        first;
    res_t        stat;

    always_comb begin
        phase_next  = phase_reg;
        fidx_next   = fidx_reg;
        fshift_next = fshift_reg;
        tag_next    = tag_reg;
        left_next   = left_reg;
        foff_next   = foff_reg;
        ext_next    = ext_reg;
        chan_next   = chan_reg;
        srate_next  = srate_reg;
        brate_next  = brate_reg;
        align_next  = align_reg;
        bits_next   = bits_reg;
        mask_next   = mask_reg;
        seen_next   = (seen_reg < 4'd12) ? seen_reg + 4'd1 : seen_reg;
        odd_next    = ~odd_reg;
        dseen_next  = dseen_reg;
        err_next    = err_reg;
        do_finish   = 1'b0;
        emit_first  = 1'b0;
        first       = '0;
        stat        = '0;
        word        = put_byte32(fshift_reg, fidx_reg, in_byte);
        fmt_size    = {1'b0, left_reg} + {27'd0, foff_reg};

        if (phase_reg <= PH_CSIZE) begin
            if (fidx_reg != 2'd3) begin
                fidx_next   = fidx_reg + 2'd1;
                fshift_next = word;
            end else begin
                fidx_next   = 2'd0;
                fshift_next = 32'd0;
                unique case (phase_reg)
                    PH_RIFF: begin
                        if (word != TAG_RIFF) begin
                            err_next   = ST_NOT_RIFF;
                            phase_next = PH_DEAD;
                        end else begin
                            phase_next = PH_RSIZE;
                        end
                    end
                    PH_RSIZE: phase_next = PH_WAVE;
                    PH_WAVE: begin
                        if (word != TAG_WAVE) begin
                            err_next   = ST_NOT_WAVE;
                            phase_next = PH_DEAD;
                        end else begin
                            phase_next = PH_CID;
                        end
                    end
                    PH_CID: begin
                        tag_next   = word;
                        phase_next = PH_CSIZE;
                    end
                    default: begin
                        left_next = word;
                        if (tag_reg == TAG_FMT) begin
                            foff_next = 6'd0;
                            ext_next  = 16'd0;
                            mask_next = 32'd0;
                        end
                        if (word == 32'd0) begin
                            do_finish = 1'b1;
                        end else begin
                            phase_next = PH_BODY;
                        end
                    end
                endcase
            end
        end else if (phase_reg == PH_BODY) begin
            if (tag_reg == TAG_FMT) begin
                if (foff_reg == 6'd2 || foff_reg == 6'd3) begin
                    chan_next = put_byte16(chan_reg, foff_reg[0], in_byte);
                end else if (foff_reg >= 6'd4 && foff_reg <= 6'd7) begin
                    srate_next = put_byte32(srate_reg, foff_reg[1:0], in_byte);
                end else if (foff_reg >= 6'd8 && foff_reg <= 6'd11) begin
                    brate_next = put_byte32(brate_reg, foff_reg[1:0], in_byte);
                end else if (foff_reg == 6'd12 || foff_reg == 6'd13) begin
                    align_next = put_byte16(align_reg, foff_reg[0], in_byte);
                end else if (foff_reg == 6'd14 || foff_reg == 6'd15) begin
                    bits_next = put_byte16(bits_reg, foff_reg[0], in_byte);
                end else if (ext_en) begin
                    if ((foff_reg == 6'd16 || foff_reg == 6'd17) && fmt_size >= 33'd18) begin
                        ext_next = put_byte16(ext_reg, foff_reg[0], in_byte);
                    end else if (foff_reg >= 6'd20 && foff_reg <= 6'd23
                                 && fmt_size >= {27'd0, FMT_EXT} && ext_reg >= EXT_MIN) begin
                        mask_next = put_byte32(mask_reg, foff_reg[1:0], in_byte);
                    end
                end
                if (foff_reg < FMT_EXT) begin
                    foff_next = foff_reg + 6'd1;
                end
            end else if (tag_reg == TAG_DATA) begin
                emit_first        = 1'b1;
                first.kind        = KIND_DATA;
                first.sample_byte = in_byte;
                first.chunk_end   = (left_reg == 32'd1);
            end
            left_next = left_reg - 32'd1;
            if (left_next == 32'd0) begin
                do_finish = 1'b1;
            end
        end else if (phase_reg == PH_PAD) begin
            phase_next = PH_CID;
        end

        // Closing a chunk: a fmt chunk either reports or flags itself as too small.
        if (do_finish) begin
            if (tag_reg == TAG_FMT && foff_next < FMT_MIN) begin
                err_next   = ST_FMT_SMALL;
                phase_next = PH_DEAD;
            end else begin
                if (tag_reg == TAG_FMT) begin
                    emit_first          = 1'b1;
                    first.kind          = KIND_FORMAT;
                    first.channels      = chan_next;
                    first.rate_hz       = srate_next;
                    first.bytes_per_sec = brate_next;
                    first.frame_bytes   = align_next;
                    first.sample_bits   = bits_next;
                    first.speaker_mask  = mask_next;
                end else if (tag_reg == TAG_DATA) begin
                    dseen_next = 1'b1;
                end
                phase_next = odd_next ? PH_PAD : PH_CID;
            end
        end

        stat.kind = KIND_STATUS;
        stat.last = 1'b1;
        if (seen_next < 4'd12) begin
            stat.status = ST_SHORT;
        end else if (err_next != ST_OK) begin
            stat.status = err_next;
        end else if (phase_next == PH_BODY) begin
            stat.status = ST_OVERRUN;
        end else begin
            stat.status = dseen_next ? ST_OK : ST_NO_DATA;
        end

        if (in_eof) begin
            phase_next  = PH_RIFF;
            fidx_next   = 2'd0;
            fshift_next = 32'd0;
            tag_next    = 32'd0;
            left_next   = 32'd0;
            foff_next   = 6'd0;
            ext_next    = 16'd0;
            chan_next   = 16'd0;
            srate_next  = 32'd0;
            brate_next  = 32'd0;
            align_next  = 16'd0;
            bits_next   = 16'd0;
            mask_next   = 32'd0;
            seen_next   = 4'd0;
            odd_next    = 1'b0;
            dseen_next  = 1'b0;
            err_next    = ST_OK;
        end
        first.last = !in_eof;
    end

    // Results are packed so the first queue slot always gets the earliest one.
    always_comb begin
        res_a   = first;
        res_b   = stat;
        res_cnt = 2'd0;
        if (in_take) begin
            if (emit_first && in_eof) begin
                res_cnt = 2'd2;
            end else if (emit_first) begin
                res_cnt = 2'd1;
            end else if (in_eof) begin
                res_a   = stat;
                res_cnt = 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_RIFF;
            fidx_reg   <= 2'd0;
            fshift_reg <= 32'd0;
            tag_reg    <= 32'd0;
            left_reg   <= 32'd0;
            foff_reg   <= 6'd0;
            ext_reg    <= 16'd0;
            chan_reg   <= 16'd0;
            srate_reg  <= 32'd0;
            brate_reg  <= 32'd0;
            align_reg  <= 16'd0;
            bits_reg   <= 16'd0;
            mask_reg   <= 32'd0;
            seen_reg   <= 4'd0;
            odd_reg    <= 1'b0;
            dseen_reg  <= 1'b0;
            err_reg    <= ST_OK;
        end else if (in_take) begin
            phase_reg  <= phase_next;
            fidx_reg   <= fidx_next;
            fshift_reg <= fshift_next;
            tag_reg    <= tag_next;
            left_reg   <= left_next;
            foff_reg   <= foff_next;
            ext_reg    <= ext_next;
            chan_reg   <= chan_next;
            srate_reg  <= srate_next;
            brate_reg  <= brate_next;
            align_reg  <= align_next;
            bits_reg   <= bits_next;
            mask_reg   <= mask_next;
            seen_reg   <= seen_next;
            odd_reg    <= odd_next;
            dseen_reg  <= dseen_next;
            err_reg    <= err_next;
        end
    end

endmodule

// ===== design/rwc_out_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwc_out_fifo
// Four-entry result queue taking up to two results per cycle.
// ----------------------------------------------------------------------------
module rwc_out_fifo
    import rwc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  res_t       push_a,
    input  res_t       push_b,
    input  logic [1:0] push_cnt,
    output logic       room,
    output logic       out_valid,
    input  logic       out_ready,
    output res_t       out_res
);

    res_t       slot_reg [4];
    logic [1:0] wr_reg, wr_next;
    logic [1:0] rd_reg, rd_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;
    logic [1:0] wr_b;

    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != 3'd0);
    assign out_res   = slot_reg[rd_reg];
    // Two free slots are needed since one byte can bring two results.
    assign room      = (cnt_reg <= 3'd2);
    assign wr_b      = wr_reg + 2'd1;

    always_comb begin
        wr_next  = wr_reg + push_cnt;
        rd_next  = rd_reg + {1'b0, pop};
        cnt_next = cnt_reg + {1'b0, push_cnt} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            slot_reg[wr_reg] <= push_a;
        end
        if (push_cnt == 2'd2) begin
            slot_reg[wr_b] <= push_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 2'd0;
            rd_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== design/riff_wav_chunk_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riff_wav_chunk_parser
// Streams a WAV file byte by byte, reports its format and forwards audio data.
// ----------------------------------------------------------------------------
// Usage: file bytes enter on the s_ channel, one byte per transfer, with
// s_tlast on the final byte of the file. Results leave on the m_ channel:
// m_tuser gives the kind (audio byte, format report, final status), m_tdata
// the payload and m_tlast marks the final result caused by one input byte.
// A byte is parsed in the cycle it is accepted and its results are written
// into the result queue that drives m_. Throughput is one byte per cycle
// while the queue has room; a byte with two results (data or format result
// plus end-of-file status) needs two output transfers, which set its rate.
// Results wait in a four-entry queue; s_tready drops while it holds more
// than two, so a stalled receiver holds the input back without loss.
// The APB register selects whether the extensible fmt extension is read.
// Reset clears the parser and queue and sets that register to 1. After the
// status result of a file the parser starts over for the next file.
// ----------------------------------------------------------------------------
module riff_wav_chunk_parser
    import rwc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // file_byte
    input  logic               s_tlast,   // end_of_file
    output logic               m_tvalid,
    input  logic               m_tready,
    // sample_byte, chunk_end, channels, rate_hz, bytes_per_sec, frame_bytes,
    // sample_bits, speaker_mask, status, zero fill
    output logic [TDATA_W-1:0] m_tdata,
    output logic [1:0]         m_tuser,   // kind
    output logic               m_tlast,   // last
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic       ext_en;
    logic       take;
    logic       room;
    res_t       res_a;
    res_t       res_b;
    res_t       out_res;
    logic [1:0] res_cnt;

    assign s_tready = room;
    assign take     = s_tvalid && room;

    rwc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .ext_en  (ext_en)
    );

    rwc_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_take (take),
        .in_byte (s_tdata),
        .in_eof  (s_tlast),
        .ext_en  (ext_en),
        .res_a   (res_a),
        .res_b   (res_b),
        .res_cnt (res_cnt)
    );

    rwc_out_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_a    (res_a),
        .push_b    (res_b),
        .push_cnt  (res_cnt),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {4'd0, out_res.status, out_res.speaker_mask, out_res.sample_bits,
                      out_res.frame_bytes, out_res.bytes_per_sec, out_res.rate_hz,
                      out_res.channels, out_res.chunk_end, out_res.sample_byte};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule
